>>> sv/bhpq_pkg.sv
`default_nettype none

package bhpq_pkg;

    // default sizing of the queue
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // request field width
    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_POP    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_FIND   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_LAST_RD,
        S_LAST_WT,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

    // strobes from the sequencer to the level cells
    typedef struct packed {
        logic rd;
        logic wr;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> sv/bhpq_cell.sv
`default_nettype none

// One heap level: holds slots 2^LEVEL-1 .. 2^(LEVEL+1)-2 (trimmed to the
// capacity). Read data is registered and merged into the response chain
// that runs from the deepest level toward the root level.
module bhpq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CAPACITY   = 64,
    parameter int LEVEL      = 0,
    parameter int AW         = 6,
    parameter int LW         = 3
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire bhpq_pkg::cell_cmd_t cmd,
    input  wire  [LW-1:0]            rd_lvl,
    input  wire  [AW-1:0]            rd_off_a,
    input  wire  [AW-1:0]            rd_off_b,
    input  wire  [LW-1:0]            wr_lvl,
    input  wire  [AW-1:0]            wr_off,
    input  wire  [DATA_WIDTH-1:0]    wr_data,
    input  wire  [DATA_WIDTH-1:0]    chain_in_a,
    input  wire  [DATA_WIDTH-1:0]    chain_in_b,
    output logic [DATA_WIDTH-1:0]    chain_out_a,
    output logic [DATA_WIDTH-1:0]    chain_out_b
);
    import bhpq_pkg::*;

    localparam int ROW   = 1 << LEVEL;
    localparam int BASE  = ROW - 1;
    localparam int DEPTH = (CAPACITY - BASE < ROW) ? (CAPACITY - BASE) : ROW;

    logic                  rd_sel;
    logic                  wr_sel;
    logic                  hit_reg;
    logic [DATA_WIDTH-1:0] rd_a_reg;
    logic [DATA_WIDTH-1:0] rd_b_reg;

    assign rd_sel = cmd.rd && (rd_lvl == LW'(LEVEL));
    assign wr_sel = cmd.wr && (wr_lvl == LW'(LEVEL));

    generate
        if (DEPTH == 1) begin : g_one
            // single slot: the offsets are not used here
            logic [DATA_WIDTH-1:0] slot_reg;

            always_ff @(posedge aclk) begin
                if (wr_sel) begin
                    slot_reg <= wr_data;
                end
                if (rd_sel) begin
                    rd_a_reg <= slot_reg;
                    rd_b_reg <= slot_reg;
                end
            end
        end else begin : g_mem
            localparam int OW = $clog2(DEPTH);
            logic [DATA_WIDTH-1:0] mem [DEPTH];

            // one write port, two registered read ports
            always_ff @(posedge aclk) begin
                if (wr_sel) begin
                    mem[wr_off[OW-1:0]] <= wr_data;
                end
                if (rd_sel) begin
                    rd_a_reg <= mem[rd_off_a[OW-1:0]];
                    rd_b_reg <= mem[rd_off_b[OW-1:0]];
                end
            end
        end
    endgenerate

    // marks that this level answers on the chain in the next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= rd_sel;
        end
    end

    // merge into the response chain
    assign chain_out_a = chain_in_a | (hit_reg ? rd_a_reg : '0);
    assign chain_out_b = chain_in_b | (hit_reg ? rd_b_reg : '0);

endmodule

`default_nettype wire

>>> sv/bhpq_ctrl.sv
`default_nettype none

// Sequencer: decodes a request, scans the levels in store order, and
// walks a carried element up or down the level cells one level at a time.
module bhpq_ctrl #(
    parameter int DATA_WIDTH = 32,
    parameter int CAPACITY   = 64,
    parameter int CW         = 7,
    parameter int AW         = 6,
    parameter int LW         = 3
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        order_mode,
    // request
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire  [bhpq_pkg::OP_W-1:0]  in_op,
    input  wire  [DATA_WIDTH-1:0]      in_value,
    // result
    output logic                       res_valid,
    input  wire                        res_ready,
    output logic [DATA_WIDTH-1:0]      res_top,
    output logic [CW-1:0]              res_count,
    output logic                       res_found,
    output bhpq_pkg::status_t          res_status,
    // level cell bus
    output bhpq_pkg::cell_cmd_t        cmd,
    output logic [LW-1:0]              rd_lvl,
    output logic [AW-1:0]              rd_off_a,
    output logic [AW-1:0]              rd_off_b,
    output logic [LW-1:0]              wr_lvl,
    output logic [AW-1:0]              wr_off,
    output logic [DATA_WIDTH-1:0]      wr_data,
    input  wire  [DATA_WIDTH-1:0]      rd_data_a,
    input  wire  [DATA_WIDTH-1:0]      rd_data_b
);
    import bhpq_pkg::*;

    localparam int IW = CW + 2;

    // heap index of (level, offset)
    function automatic logic [IW-1:0] idx_of(input logic [LW-1:0] l,
                                             input logic [AW-1:0] o);
        idx_of = (IW'(1) << l) - IW'(1) + IW'(o);
    endfunction

    // level of a heap index: position of the top set bit of index+1
    function automatic logic [LW-1:0] lvl_of(input logic [IW-1:0] n);
        logic [IW-1:0] m;
        m = n + IW'(1);
        lvl_of = '0;
        for (int b = 0; b < IW; b++) begin
            if (m[b]) begin
                lvl_of = LW'(b);
            end
        end
    endfunction

    function automatic logic [AW-1:0] off_of(input logic [IW-1:0] n,
                                             input logic [LW-1:0] l);
        logic [IW-1:0] d;
        d = n + IW'(1) - (IW'(1) << l);
        off_of = d[AW-1:0];
    endfunction

    // true when a may sit above b
    function automatic logic ranks(input logic [DATA_WIDTH-1:0] a,
                                   input logic [DATA_WIDTH-1:0] b,
                                   input logic mode);
        ranks = mode ? ($signed(a) >= $signed(b)) : ($signed(a) <= $signed(b));
    endfunction

    state_t                state_reg,     state_next;
    op_t                   op_reg,        op_next;
    logic [DATA_WIDTH-1:0] val_reg,       val_next;
    logic [CW-1:0]         count_reg,     count_next;
    logic [DATA_WIDTH-1:0] root_reg,      root_next;
    logic                  found_reg,     found_next;
    status_t               status_reg,    status_next;
    logic [LW-1:0]         pos_lvl_reg,   pos_lvl_next;
    logic [AW-1:0]         pos_off_reg,   pos_off_next;
    logic [DATA_WIDTH-1:0] carry_reg,     carry_next;
    logic [LW-1:0]         tgt_lvl_reg,   tgt_lvl_next;
    logic [AW-1:0]         tgt_off_reg,   tgt_off_next;
    logic [LW-1:0]         hit_lvl_reg,   hit_lvl_next;
    logic [AW-1:0]         hit_off_reg,   hit_off_next;
    logic [IW-1:0]         hit_idx_reg,   hit_idx_next;
    logic                  rm_reg,        rm_next;
    logic                  up_first_reg,  up_first_next;
    logic [DATA_WIDTH-1:0] start_val_reg, start_val_next;
    logic [LW-1:0]         scan_lvl_reg,  scan_lvl_next;
    logic [AW-1:0]         scan_off_reg,  scan_off_next;
    logic [IW-1:0]         scan_idx_reg,  scan_idx_next;
    logic                  chk_vld_reg,   chk_vld_next;
    logic [LW-1:0]         chk_lvl_reg,   chk_lvl_next;
    logic [AW-1:0]         chk_off_reg,   chk_off_next;
    logic [IW-1:0]         chk_idx_reg,   chk_idx_next;

    // next state and cell commands
    always_comb begin
        logic [IW-1:0] n_last;
        logic [LW-1:0] last_lvl;
        logic [LW-1:0] ins_lvl;
        logic [IW-1:0] l_idx;
        logic          r_in;

        n_last   = IW'(count_reg) - IW'(1);
        last_lvl = lvl_of(n_last);
        ins_lvl  = lvl_of(IW'(count_reg));
        l_idx    = (idx_of(pos_lvl_reg, pos_off_reg) << 1) + IW'(1);
        r_in     = (l_idx + IW'(1)) < IW'(count_reg);

        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        root_next      = root_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        pos_lvl_next   = pos_lvl_reg;
        pos_off_next   = pos_off_reg;
        carry_next     = carry_reg;
        tgt_lvl_next   = tgt_lvl_reg;
        tgt_off_next   = tgt_off_reg;
        hit_lvl_next   = hit_lvl_reg;
        hit_off_next   = hit_off_reg;
        hit_idx_next   = hit_idx_reg;
        rm_next        = rm_reg;
        up_first_next  = up_first_reg;
        start_val_next = start_val_reg;
        scan_lvl_next  = scan_lvl_reg;
        scan_off_next  = scan_off_reg;
        scan_idx_next  = scan_idx_reg;
        chk_vld_next   = chk_vld_reg;
        chk_lvl_next   = chk_lvl_reg;
        chk_off_next   = chk_off_reg;
        chk_idx_next   = chk_idx_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        cmd       = '0;
        rd_lvl    = pos_lvl_reg;
        rd_off_a  = pos_off_reg;
        rd_off_b  = pos_off_reg;
        wr_lvl    = pos_lvl_reg;
        wr_off    = pos_off_reg;
        wr_data   = carry_reg;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next       = op_t'(in_op);
                    val_next      = in_value;
                    found_next    = 1'b0;
                    status_next   = ST_OK;
                    rm_next       = 1'b0;
                    up_first_next = 1'b1;
                    chk_vld_next  = 1'b0;
                    scan_lvl_next = '0;
                    scan_off_next = '0;
                    scan_idx_next = '0;
                    tgt_lvl_next  = last_lvl;
                    tgt_off_next  = off_of(n_last, last_lvl);
                    case (op_t'(in_op))
                        OP_INSERT: begin
                            if (count_reg == CW'(CAPACITY)) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                pos_lvl_next = ins_lvl;
                                pos_off_next = off_of(IW'(count_reg), ins_lvl);
                                carry_next   = in_value;
                                count_next   = count_reg + CW'(1);
                                state_next   = S_UP_RD;
                            end
                        end
                        OP_POP: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                count_next = count_reg - CW'(1);
                                state_next = S_LAST_RD;
                            end
                        end
                        OP_REMOVE: begin
                            status_next = ST_MISS;
                            state_next  = (count_reg == '0) ? S_DONE : S_SCAN;
                        end
                        OP_FIND: begin
                            state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // one slot read per cycle, compared in the next cycle
            S_SCAN: begin
                chk_vld_next = 1'b0;
                if (scan_idx_reg < IW'(count_reg)) begin
                    cmd.rd        = 1'b1;
                    rd_lvl        = scan_lvl_reg;
                    rd_off_a      = scan_off_reg;
                    rd_off_b      = scan_off_reg;
                    chk_vld_next  = 1'b1;
                    chk_lvl_next  = scan_lvl_reg;
                    chk_off_next  = scan_off_reg;
                    chk_idx_next  = scan_idx_reg;
                    scan_idx_next = scan_idx_reg + IW'(1);
                    if (IW'(scan_off_reg) == (IW'(1) << scan_lvl_reg) - IW'(1)) begin
                        scan_lvl_next = scan_lvl_reg + LW'(1);
                        scan_off_next = '0;
                    end else begin
                        scan_off_next = scan_off_reg + AW'(1);
                    end
                end
                if (chk_vld_reg) begin
                    if (rd_data_a == val_reg) begin
                        found_next   = 1'b1;
                        chk_vld_next = 1'b0;
                        if (op_reg == OP_REMOVE) begin
                            status_next  = ST_OK;
                            count_next   = count_reg - CW'(1);
                            hit_lvl_next = chk_lvl_reg;
                            hit_off_next = chk_off_reg;
                            hit_idx_next = chk_idx_reg;
                            state_next   = S_LAST_RD;
                        end else begin
                            state_next = S_DONE;
                        end
                    end else if (chk_idx_reg == n_last) begin
                        chk_vld_next = 1'b0;
                        state_next   = S_DONE;
                    end
                end
            end

            // fetch the last element
            S_LAST_RD: begin
                cmd.rd     = 1'b1;
                rd_lvl     = tgt_lvl_reg;
                rd_off_a   = tgt_off_reg;
                rd_off_b   = tgt_off_reg;
                state_next = S_LAST_WT;
            end

            S_LAST_WT: begin
                carry_next = rd_data_a;
                if (op_reg == OP_POP) begin
                    pos_lvl_next = '0;
                    pos_off_next = '0;
                    state_next   = S_DN_RD;
                end else if (hit_idx_reg == IW'(count_reg)) begin
                    // removed the last slot itself
                    state_next = S_DONE;
                end else begin
                    pos_lvl_next = hit_lvl_reg;
                    pos_off_next = hit_off_reg;
                    rm_next      = 1'b1;
                    state_next   = S_UP_RD;
                end
            end

            S_UP_RD: begin
                if (pos_lvl_reg == '0) begin
                    cmd.wr = 1'b1;
                    if (rm_reg) begin
                        rm_next      = 1'b0;
                        pos_lvl_next = hit_lvl_reg;
                        pos_off_next = hit_off_reg;
                        carry_next   = up_first_reg ? carry_reg : start_val_reg;
                        state_next   = S_DN_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    cmd.rd     = 1'b1;
                    rd_lvl     = pos_lvl_reg - LW'(1);
                    rd_off_a   = pos_off_reg >> 1;
                    rd_off_b   = pos_off_reg >> 1;
                    state_next = S_UP_CMP;
                end
            end

            // parent value is on the chain
            S_UP_CMP: begin
                cmd.wr = 1'b1;
                if (ranks(rd_data_a, carry_reg, order_mode)) begin
                    if (rm_reg) begin
                        rm_next      = 1'b0;
                        pos_lvl_next = hit_lvl_reg;
                        pos_off_next = hit_off_reg;
                        carry_next   = up_first_reg ? carry_reg : start_val_reg;
                        state_next   = S_DN_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    wr_data = rd_data_a;
                    if (up_first_reg) begin
                        start_val_next = rd_data_a;
                        up_first_next  = 1'b0;
                    end
                    pos_lvl_next = pos_lvl_reg - LW'(1);
                    pos_off_next = pos_off_reg >> 1;
                    state_next   = S_UP_RD;
                end
            end

            S_DN_RD: begin
                if (l_idx >= IW'(count_reg)) begin
                    cmd.wr     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.rd     = 1'b1;
                    rd_lvl     = pos_lvl_reg + LW'(1);
                    rd_off_a   = pos_off_reg << 1;
                    rd_off_b   = (pos_off_reg << 1) | AW'(1);
                    state_next = S_DN_CMP;
                end
            end

            // both children are on the chain
            S_DN_CMP: begin
                cmd.wr = 1'b1;
                if (!r_in) begin
                    if (!ranks(carry_reg, rd_data_a, order_mode)) begin
                        wr_data      = rd_data_a;
                        pos_lvl_next = pos_lvl_reg + LW'(1);
                        pos_off_next = pos_off_reg << 1;
                        state_next   = S_DN_RD;
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (ranks(carry_reg, rd_data_a, order_mode) &&
                             ranks(carry_reg, rd_data_b, order_mode)) begin
                    state_next = S_DONE;
                end else if (!ranks(rd_data_b, rd_data_a, order_mode)) begin
                    wr_data      = rd_data_a;
                    pos_lvl_next = pos_lvl_reg + LW'(1);
                    pos_off_next = pos_off_reg << 1;
                    state_next   = S_DN_RD;
                end else begin
                    // equal rank picks the right child
                    wr_data      = rd_data_b;
                    pos_lvl_next = pos_lvl_reg + LW'(1);
                    pos_off_next = (pos_off_reg << 1) | AW'(1);
                    state_next   = S_DN_RD;
                end
            end

            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // shadow of the root slot
        if (cmd.wr && (wr_lvl == '0)) begin
            root_next = wr_data;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rm_reg       <= 1'b0;
            up_first_reg <= 1'b1;
            chk_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rm_reg       <= rm_next;
            up_first_reg <= up_first_next;
            chk_vld_reg  <= chk_vld_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        root_reg      <= root_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        pos_lvl_reg   <= pos_lvl_next;
        pos_off_reg   <= pos_off_next;
        carry_reg     <= carry_next;
        tgt_lvl_reg   <= tgt_lvl_next;
        tgt_off_reg   <= tgt_off_next;
        hit_lvl_reg   <= hit_lvl_next;
        hit_off_reg   <= hit_off_next;
        hit_idx_reg   <= hit_idx_next;
        start_val_reg <= start_val_next;
        scan_lvl_reg  <= scan_lvl_next;
        scan_off_reg  <= scan_off_next;
        scan_idx_reg  <= scan_idx_next;
        chk_lvl_reg   <= chk_lvl_next;
        chk_off_reg   <= chk_off_next;
        chk_idx_reg   <= chk_idx_next;
    end

    assign res_top    = (count_reg != '0) ? root_reg : '0;
    assign res_count  = count_reg;
    assign res_found  = found_reg;
    assign res_status = status_reg;

endmodule

`default_nettype wire

>>> sv/binary_heap_priority_queue_core.sv
// Bounded binary-heap priority queue of signed words. Each input beat is one
// request (insert, pop top, remove one occurrence, find, clear) and yields
// exactly one result beat with the top value, count, empty flag, found flag
// and status. The heap is stored as a row of level cells, one memory per
// heap level, and a sequencer walks the carried element across the levels.
// One request is worked on at a time; a new request is taken as soon as the
// previous result sits in the output register. Insert climbs the new element
// toward the root and pop descends the last element from the root. Find and
// remove scan the slots in store order, one slot per cycle through the
// registered cell read; remove on a hit then fetches the last element and
// climbs and descends the moved element. Ordering is set by cfg_data (0
// smallest on top, 1 largest on top); writing it does not reorder stored
// elements. After reset the queue is empty and ready at once.
`default_nettype none

module binary_heap_priority_queue_core #(
    parameter int CAPACITY   = bhpq_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = bhpq_pkg::DEF_DATA_WIDTH
) (
    input  wire  aclk,
    input  wire  aresetn,
    // request: [2:0] op, [DATA_WIDTH+2:3] value, zero padded to bytes
    input  wire  s_tvalid,
    output logic s_tready,
    input  wire  [((DATA_WIDTH + bhpq_pkg::OP_W + 7) / 8) * 8 - 1:0] s_tdata,
    // result: top_value, count, is_empty, found, status[1:0], zero padded
    output logic m_tvalid,
    input  wire  m_tready,
    output logic [((DATA_WIDTH + $clog2(CAPACITY + 1) + 4 + 7) / 8) * 8 - 1:0] m_tdata,
    // order register write
    input  wire  cfg_valid,
    output logic cfg_ready,
    input  wire  cfg_data
);
    import bhpq_pkg::*;

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int AW  = $clog2(CAPACITY);
    localparam int NL  = CW;
    localparam int LW  = $clog2(NL + 1);
    localparam int M_W = ((DATA_WIDTH + CW + 4 + 7) / 8) * 8;

    logic                  order_mode_reg;
    logic                  m_tvalid_reg;
    logic [M_W-1:0]        m_tdata_reg;
    logic                  res_valid;
    logic                  res_ready;
    logic [DATA_WIDTH-1:0] res_top;
    logic [CW-1:0]         res_count;
    logic                  res_found;
    status_t               res_status;
    cell_cmd_t             cmd;
    logic [LW-1:0]         rd_lvl;
    logic [AW-1:0]         rd_off_a;
    logic [AW-1:0]         rd_off_b;
    logic [LW-1:0]         wr_lvl;
    logic [AW-1:0]         wr_off;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] chain_a [NL+1];
    logic [DATA_WIDTH-1:0] chain_b [NL+1];

    // order register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            order_mode_reg <= cfg_data;
        end
    end

    bhpq_ctrl #(
        .DATA_WIDTH (DATA_WIDTH),
        .CAPACITY   (CAPACITY),
        .CW         (CW),
        .AW         (AW),
        .LW         (LW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .order_mode (order_mode_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tdata[OP_W-1:0]),
        .in_value   (s_tdata[DATA_WIDTH+OP_W-1:OP_W]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_top    (res_top),
        .res_count  (res_count),
        .res_found  (res_found),
        .res_status (res_status),
        .cmd        (cmd),
        .rd_lvl     (rd_lvl),
        .rd_off_a   (rd_off_a),
        .rd_off_b   (rd_off_b),
        .wr_lvl     (wr_lvl),
        .wr_off     (wr_off),
        .wr_data    (wr_data),
        .rd_data_a  (chain_a[0]),
        .rd_data_b  (chain_b[0])
    );

    // level cells, response chain from the deepest level to the root
    assign chain_a[NL] = '0;
    assign chain_b[NL] = '0;

    for (genvar l = 0; l < NL; l++) begin : g_level
        bhpq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CAPACITY   (CAPACITY),
            .LEVEL      (l),
            .AW         (AW),
            .LW         (LW)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .rd_lvl      (rd_lvl),
            .rd_off_a    (rd_off_a),
            .rd_off_b    (rd_off_b),
            .wr_lvl      (wr_lvl),
            .wr_off      (wr_off),
            .wr_data     (wr_data),
            .chain_in_a  (chain_a[l+1]),
            .chain_in_b  (chain_b[l+1]),
            .chain_out_a (chain_a[l]),
            .chain_out_b (chain_b[l])
        );
    end

    // result register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= M_W'({res_status, res_found, (res_count == '0),
                                 res_count, res_top});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> sv/bhpq_checker.sv
`default_nettype none

module bhpq_checker #(
    parameter int CAPACITY   = bhpq_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = bhpq_pkg::DEF_DATA_WIDTH
) (
    input wire aclk,
    input wire aresetn,
    input wire m_tvalid,
    input wire m_tready,
    input wire [((DATA_WIDTH + $clog2(CAPACITY + 1) + 4 + 7) / 8) * 8 - 1:0] m_tdata
);
    import bhpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [DATA_WIDTH-1:0] top_value;
    logic [CW-1:0]         count;
    logic                  is_empty;
    logic                  found;
    logic [1:0]            status;

    // result beat fields
    assign top_value = m_tdata[DATA_WIDTH-1:0];
    assign count     = m_tdata[DATA_WIDTH+CW-1:DATA_WIDTH];
    assign is_empty  = m_tdata[DATA_WIDTH+CW];
    assign found     = m_tdata[DATA_WIDTH+CW+1];
    assign status    = m_tdata[DATA_WIDTH+CW+3:DATA_WIDTH+CW+2];

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat offered right after reset");

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // empty flag follows the count
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (is_empty == (count == '0)))
        else $error("is_empty disagrees with count");

    // empty queue reports a zero top
    a_top_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && is_empty |-> (top_value == '0))
        else $error("nonzero top_value on empty queue");

    // a match never carries an error status or a count beyond capacity
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && found |-> (status == ST_OK) && (count <= CW'(CAPACITY)))
        else $error("found with error status or count beyond capacity");

endmodule

bind binary_heap_priority_queue_core bhpq_checker #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
) u_bhpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/heap_result_checker.sv
// Watches the request, result and order channels of the heap queue, keeps
// its own copy of the heap, and compares every result beat with the oldest
// predicted one.
module heap_result_checker #(
    parameter int CAPACITY = bhpq_pkg::DEF_CAPACITY,
    parameter int DW       = bhpq_pkg::DEF_DATA_WIDTH,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int S_W      = ((DW + bhpq_pkg::OP_W + 7) / 8) * 8,
    parameter int M_W      = ((DW + CNT_W + 4 + 7) / 8) * 8
) (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           s_tvalid,
    input  wire           s_tready,
    input  wire [S_W-1:0] s_tdata,
    input  wire           m_tvalid,
    input  wire           m_tready,
    input  wire [M_W-1:0] m_tdata,
    input  wire           cfg_valid,
    input  wire           cfg_ready,
    input  wire           cfg_data,
    output int            fail_count,
    output int            outstanding
);
    import bhpq_pkg::*;

    typedef struct packed {
        logic [DW-1:0]    top;
        logic [CNT_W-1:0] cnt;
        logic             empty;
        logic             found;
        logic [1:0]       status;
    } heap_result_t;

    // shadow heap
    logic signed [DW-1:0] heap_mem [0:CAPACITY-1];
    int                   heap_cnt;
    logic                 order_max;

    heap_result_t pending_results [$];
    heap_result_t want;
    int           fail_cnt;

    // slot a may sit above slot b under the current order
    function automatic bit outranks(int a, int b);
        if (order_max)
            return heap_mem[a] >= heap_mem[b];
        return heap_mem[a] <= heap_mem[b];
    endfunction

    function automatic void swap_slots(int a, int b);
        logic signed [DW-1:0] t;
        t           = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    function automatic void bubble_up(int pos);
        int parent;
        while (pos != 0) begin
            parent = (pos - 1) / 2;
            if (outranks(parent, pos))
                return;
            swap_slots(pos, parent);
            pos = parent;
        end
    endfunction

    // ties between children go to the right child
    function automatic void bubble_down(int pos);
        int lc;
        int rc;
        while (pos < heap_cnt) begin
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc >= heap_cnt)
                return;
            if (rc >= heap_cnt) begin
                if (!outranks(pos, lc))
                    swap_slots(pos, lc);
                return;
            end
            if (outranks(pos, lc) && outranks(pos, rc))
                return;
            if (!outranks(rc, lc)) begin
                swap_slots(pos, lc);
                pos = lc;
            end else begin
                swap_slots(pos, rc);
                pos = rc;
            end
        end
    endfunction

    // apply one request to the shadow heap and build its result
    function automatic heap_result_t heap_apply(logic [OP_W-1:0] op,
                                                logic signed [DW-1:0] value);
        heap_result_t r;
        int i;
        r.found  = 1'b0;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (heap_cnt >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    heap_mem[heap_cnt] = value;
                    heap_cnt++;
                    bubble_up(heap_cnt - 1);
                end
            end
            OP_POP: begin
                if (heap_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    heap_cnt--;
                    heap_mem[0] = heap_mem[heap_cnt];
                    bubble_down(0);
                end
            end
            OP_REMOVE: begin
                // first match in store order; moved element may go either way
                r.status = ST_MISS;
                for (i = 0; i < heap_cnt; i++) begin
                    if (heap_mem[i] == value) begin
                        r.found  = 1'b1;
                        r.status = ST_OK;
                        heap_cnt--;
                        heap_mem[i] = heap_mem[heap_cnt];
                        if (i < heap_cnt) begin
                            bubble_up(i);
                            bubble_down(i);
                        end
                        break;
                    end
                end
            end
            OP_FIND: begin
                for (i = 0; i < heap_cnt; i++) begin
                    if (heap_mem[i] == value) begin
                        r.found = 1'b1;
                        break;
                    end
                end
            end
            OP_CLEAR: begin
                heap_cnt = 0;
            end
            default: begin
                // undefined opcodes leave the heap alone
            end
        endcase
        r.top   = (heap_cnt != 0) ? heap_mem[0] : '0;
        r.cnt   = CNT_W'(heap_cnt);
        r.empty = (heap_cnt == 0);
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, name, exp_val, act_val);
            fail_cnt++;
        end
    endtask

    // track beats on all three channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            heap_cnt  = 0;
            order_max = 1'b0;
            pending_results.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                order_max = cfg_data;
            if (s_tvalid && s_tready)
                pending_results.insert(pending_results.size(),
                                       heap_apply(s_tdata[OP_W-1:0],
                                                  s_tdata[OP_W+DW-1:OP_W]));
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_tdata);
                    fail_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("top_value", want.top,    m_tdata[DW-1:0]);
                    check_field("count",     want.cnt,    m_tdata[DW+CNT_W-1:DW]);
                    check_field("is_empty",  want.empty,  m_tdata[DW+CNT_W]);
                    check_field("found",     want.found,  m_tdata[DW+CNT_W+1]);
                    check_field("status",    want.status, m_tdata[DW+CNT_W+3:DW+CNT_W+2]);
                end
            end
        end
        outstanding <= pending_results.size();
        fail_count  <= fail_cnt;
    end

endmodule

>>> tb/tb_binary_heap_priority_queue_core.sv
module tb_binary_heap_priority_queue_core;
    import bhpq_pkg::*;

    localparam int CAPACITY       = DEF_CAPACITY;
    localparam int DW             = DEF_DATA_WIDTH;
    localparam int CNT_W          = $clog2(CAPACITY + 1);
    localparam int S_W            = ((DW + OP_W + 7) / 8) * 8;
    localparam int M_W            = ((DW + CNT_W + 4 + 7) / 8) * 8;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 100;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 5000;

    // opcodes the block does not define
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    localparam logic [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           s_tvalid  = 1'b0;
    wire            s_tready;
    logic [S_W-1:0] s_tdata   = '0;   // [2:0] op, [34:3] value, zero pad
    wire            m_tvalid;
    logic           m_tready  = 1'b0;
    wire  [M_W-1:0] m_tdata;          // top_value, count, is_empty, found, status
    logic           cfg_valid = 1'b0;
    wire            cfg_ready;
    logic           cfg_data  = 1'b0;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    bit calm         = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    binary_heap_priority_queue_core #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DW)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    heap_result_checker #(
        .CAPACITY (CAPACITY),
        .DW       (DW)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // result side backpressure
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 9);
    end

    // watchdog: cycles without any beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one request beat, with random idle cycles ahead of it
    task automatic send_req(input logic [OP_W-1:0] op, input logic [DW-1:0] value);
        while (!calm && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {{(S_W-OP_W-DW){1'b0}}, value, op};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // stop sending and wait for every result to come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic write_order(input logic mode);
        wait_drained();
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int              phase_idx;
        int              n;
        int              pick;
        int              p_ins;
        int              p_pop;
        int              p_rem;
        int              p_find;
        int              p_clr;
        logic [OP_W-1:0] op;
        logic [DW-1:0]   v;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cases, extremes, reserved ops, ties, clear
        send_req(OP_POP,    '0);
        send_req(OP_REMOVE, 32'd5);
        send_req(OP_FIND,   '0);
        send_req(OP_RSVD_FIRST,  $urandom());
        send_req(OP_RSVD_FIRST + 3'd1, $urandom());
        send_req(OP_RSVD_LAST,   $urandom());
        send_req(OP_INSERT, VAL_MAX);
        send_req(OP_INSERT, VAL_MIN);
        send_req(OP_INSERT, '0);
        send_req(OP_INSERT, '1);
        send_req(OP_INSERT, VAL_MAX);
        send_req(OP_FIND,   VAL_MIN);
        send_req(OP_FIND,   32'd12345);
        send_req(OP_REMOVE, '1);
        send_req(OP_REMOVE, 32'd77);
        send_req(OP_POP,    '0);
        send_req(OP_INSERT, 32'd3);
        send_req(OP_INSERT, 32'd3);
        send_req(OP_INSERT, 32'd3);
        send_req(OP_POP,    '0);
        send_req(OP_POP,    '0);
        send_req(OP_CLEAR,  $urandom());
        send_req(OP_POP,    '0);
        send_req(OP_INSERT, 32'd1);
        send_req(OP_CLEAR,  '0);

        // random phases: fill, drain, mixed; order flips keep stored data
        for (phase_idx = 0; phase_idx < PHASES; phase_idx++) begin
            if (phase_idx == 0)
                write_order(1'b1);
            else if (phase_idx == 1)
                write_order(1'b0);
            else
                write_order(1'($urandom_range(0, 1)));
            calm = (phase_idx == 3);
            case (phase_idx % 3)
                0: begin
                    p_ins = 80; p_pop = 85; p_rem = 90; p_find = 97; p_clr = 97;
                end
                1: begin
                    p_ins = 15; p_pop = 75; p_rem = 90; p_find = 98; p_clr = 98;
                end
                default: begin
                    p_ins = 35; p_pop = 60; p_rem = 75; p_find = 90; p_clr = 95;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < p_ins)
                    op = OP_INSERT;
                else if (pick < p_pop)
                    op = OP_POP;
                else if (pick < p_rem)
                    op = OP_REMOVE;
                else if (pick < p_find)
                    op = OP_FIND;
                else if (pick < p_clr)
                    op = OP_CLEAR;
                else
                    op = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
                // small pool gives duplicates and hits, the rest spans all bits
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    v = DW'($urandom_range(0, 15)) - DW'(8);
                end else if (pick < 70) begin
                    case ($urandom_range(0, 3))
                        0:       v = VAL_MIN;
                        1:       v = VAL_MAX;
                        2:       v = '0;
                        default: v = '1;
                    endcase
                end else begin
                    v = $urandom();
                end
                send_req(op, v);
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
